/* hw/rtl/odo_pkg.sv */
// Shared types, fixed-point constants and the arctangent table for the odometry block.
`default_nettype none

package odo_pkg;

  // Field and datapath widths.
  localparam int DELTA_W  = 4;
  localparam int STEP_W   = 16;
  localparam int GAIN_W   = 13;
  localparam int POS_W    = 32;
  localparam int ANG_W    = 19;
  localparam int Z_W      = 20;
  localparam int VEC_W    = 19;
  localparam int TRV_W    = 22;
  localparam int MUL_B_W  = 19;
  localparam int PROD_W   = 41;
  localparam int ATAN_W   = 17;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam int ATAN_ENTRIES = 24;

  // Q16 angle constants.
  localparam logic signed [Z_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [Z_W-1:0] TWO_PI_Q16  = 20'sd411775;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

  // CORDIC start vector: the inverse gain in Q16.
  localparam logic signed [VEC_W-1:0] CORDIC_K_Q16 = 19'sd39797;

  // Half an LSB of the Q17 x Q16 product, for rounding down to Q16.16.
  localparam logic signed [PROD_W-1:0] RND_HALF = 41'sd65536;
  localparam int RND_SHIFT = 17;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 1'b1;

  typedef struct packed {
    logic                    start;
    logic signed [ANG_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VEC_W-1:0] cos_v;
    logic signed [VEC_W-1:0] sin_v;
  } cordic_res_t;

  // atan(2^-i) in Q16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [CNT_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 17'd51472;
      5'd1:    val = 17'd30386;
      5'd2:    val = 17'd16055;
      5'd3:    val = 17'd8150;
      5'd4:    val = 17'd4091;
      5'd5:    val = 17'd2047;
      5'd6:    val = 17'd1024;
      5'd7:    val = 17'd512;
      5'd8:    val = 17'd256;
      5'd9:    val = 17'd128;
      5'd10:   val = 17'd64;
      5'd11:   val = 17'd32;
      5'd12:   val = 17'd16;
      5'd13:   val = 17'd8;
      5'd14:   val = 17'd4;
      5'd15:   val = 17'd2;
      5'd16:   val = 17'd1;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/odo_cordic.sv */
// Iterative rotation-mode CORDIC that gives cos and sin of a Q16 heading.
`default_nettype none

module odo_cordic #(
  parameter int ITERS = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire odo_pkg::cordic_req_t req,
  output odo_pkg::cordic_res_t      res
);

  localparam logic [odo_pkg::CNT_W-1:0] LAST_IDX = odo_pkg::CNT_W'(ITERS - 1);

  logic signed [odo_pkg::Z_W-1:0]   z_r, z_nxt;
  logic signed [odo_pkg::VEC_W-1:0] vx_r, vx_nxt;
  logic signed [odo_pkg::VEC_W-1:0] vy_r, vy_nxt;
  logic [odo_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic                             flip_r, flip_nxt;

  logic signed [odo_pkg::Z_W-1:0]   angle_ext;
  logic signed [odo_pkg::Z_W-1:0]   atan_val;
  logic signed [odo_pkg::VEC_W-1:0] dx;
  logic signed [odo_pkg::VEC_W-1:0] dy;

  assign angle_ext = {req.angle[odo_pkg::ANG_W-1], req.angle};
  assign atan_val  = $signed({{(odo_pkg::Z_W - odo_pkg::ATAN_W){1'b0}},
                              odo_pkg::atan_lut(cnt_r)});
  assign dx = vy_r >>> cnt_r;
  assign dy = vx_r >>> cnt_r;

  always_comb begin
    z_nxt    = z_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // Angles beyond a quarter turn are folded by half a turn; the result is negated.
      if (angle_ext > odo_pkg::HALF_PI_Q16) begin
        z_nxt    = angle_ext - odo_pkg::PI_Q16;
        flip_nxt = 1'b1;
      end else if (angle_ext < -odo_pkg::HALF_PI_Q16) begin
        z_nxt    = angle_ext + odo_pkg::PI_Q16;
        flip_nxt = 1'b1;
      end else begin
        z_nxt    = angle_ext;
        flip_nxt = 1'b0;
      end
      vx_nxt   = odo_pkg::CORDIC_K_Q16;
      vy_nxt   = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[odo_pkg::Z_W-1]) begin
        vx_nxt = vx_r - dx;
        vy_nxt = vy_r + dy;
        z_nxt  = z_r - atan_val;
      end else begin
        vx_nxt = vx_r + dx;
        vy_nxt = vy_r - dy;
        z_nxt  = z_r + atan_val;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    z_r    <= z_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    flip_r <= flip_nxt;
  end

  assign res.done  = done_r;
  assign res.cos_v = flip_r ? -vx_r : vx_r;
  assign res.sin_v = flip_r ? -vy_r : vy_r;

endmodule

`default_nettype wire

/* hw/rtl/odo_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module odo_mul (
  input  wire                                 clk,
  input  wire signed [odo_pkg::TRV_W-1:0]     a,
  input  wire signed [odo_pkg::MUL_B_W-1:0]   b,
  output logic signed [odo_pkg::PROD_W-1:0]   p_r
);

  logic signed [odo_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = odo_pkg::PROD_W'(a) * odo_pkg::PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/differential_drive_odometry.sv */
// Top level of the differential-drive odometry block: sequencer, pose registers, config.
`default_nettype none

// Dead-reckoning odometry for a two-wheel robot. Each input word carries the signed
// left and right encoder count changes of one tick; the block advances x and y by the
// travel along the current heading, then turns the heading by turn_gain times the count
// difference, wrapped once into minus pi to pi. One result word (x, y in Q16.16 metres,
// heading in Q16 radians) follows every input word. The CORDIC iteration count is
// CORDIC_STEPS, capped at 24. A tick runs the iterative CORDIC, which does one rotation
// per cycle, followed by four passes through the one shared multiplier. A new word is
// taken only after the previous result has been taken. Configuration writes are accepted
// in every cycle and should be issued while the block is idle.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [odo_pkg::DELTA_W-1:0]     in_left_delta,
  input  wire signed [odo_pkg::DELTA_W-1:0]     in_right_delta,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [odo_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [odo_pkg::POS_W-1:0]      out_pos_y,
  output logic signed [odo_pkg::ANG_W-1:0]      out_heading,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [odo_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [odo_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int ITERS = (CORDIC_STEPS > odo_pkg::ATAN_ENTRIES) ?
                         odo_pkg::ATAN_ENTRIES : CORDIC_STEPS;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CORD = 8'b0000_0010,
    ST_MTRV = 8'b0000_0100,
    ST_MX   = 8'b0000_1000,
    ST_AX   = 8'b0001_0000,
    ST_AY   = 8'b0010_0000,
    ST_ATH  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [odo_pkg::DELTA_W-1:0] dl_r, dl_nxt;
  logic signed [odo_pkg::DELTA_W-1:0] dr_r, dr_nxt;
  logic [odo_pkg::STEP_W-1:0]         step_r, step_nxt;
  logic [odo_pkg::GAIN_W-1:0]         gain_r, gain_nxt;
  logic signed [odo_pkg::TRV_W-1:0]   travel_r, travel_nxt;
  logic signed [odo_pkg::POS_W-1:0]   x_acc_r, x_acc_nxt;
  logic signed [odo_pkg::POS_W-1:0]   y_acc_r, y_acc_nxt;
  logic signed [odo_pkg::ANG_W-1:0]   ang_r, ang_nxt;

  odo_pkg::cordic_req_t cord_req;
  odo_pkg::cordic_res_t cord_res;

  logic signed [odo_pkg::TRV_W-1:0]   mul_a;
  logic signed [odo_pkg::MUL_B_W-1:0] mul_b;
  logic signed [odo_pkg::PROD_W-1:0]  mul_p;

  logic signed [odo_pkg::DELTA_W:0]   sum_d;
  logic signed [odo_pkg::DELTA_W:0]   diff_d;
  logic signed [odo_pkg::PROD_W-1:0]  rnd;
  logic signed [odo_pkg::PROD_W-1:0]  rnd_sh;
  logic signed [odo_pkg::POS_W-1:0]   pos_sel;
  logic signed [odo_pkg::POS_W:0]     pos_sum;
  logic signed [odo_pkg::POS_W-1:0]   pos_sat;
  logic signed [odo_pkg::Z_W-1:0]     th;
  logic signed [odo_pkg::Z_W-1:0]     th_wrap;
  logic                               in_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign out_pos_x   = x_acc_r;
  assign out_pos_y   = y_acc_r;
  assign out_heading = ang_r;

  assign sum_d  = {dl_r[odo_pkg::DELTA_W-1], dl_r} + {dr_r[odo_pkg::DELTA_W-1], dr_r};
  assign diff_d = {dl_r[odo_pkg::DELTA_W-1], dl_r} - {dr_r[odo_pkg::DELTA_W-1], dr_r};

  assign cord_req.start = in_acc;
  assign cord_req.angle = ang_r;

  odo_cordic #(
    .ITERS (ITERS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cord_req),
    .res   (cord_res)
  );

  // Multiplier operands per step: travel, travel * cos, travel * sin, heading turn.
  always_comb begin
    case (state_r)
      ST_MTRV: begin
        mul_a = $signed({{(odo_pkg::TRV_W - odo_pkg::STEP_W){1'b0}}, step_r});
        mul_b = {{(odo_pkg::MUL_B_W - odo_pkg::DELTA_W - 1){sum_d[odo_pkg::DELTA_W]}},
                 sum_d};
      end
      ST_MX: begin
        mul_a = mul_p[odo_pkg::TRV_W-1:0];
        mul_b = cord_res.cos_v;
      end
      ST_AX: begin
        mul_a = travel_r;
        mul_b = cord_res.sin_v;
      end
      ST_AY: begin
        mul_a = $signed({{(odo_pkg::TRV_W - odo_pkg::GAIN_W){1'b0}}, gain_r});
        mul_b = {{(odo_pkg::MUL_B_W - odo_pkg::DELTA_W - 1){diff_d[odo_pkg::DELTA_W]}},
                 diff_d};
      end
      default: begin
        mul_a = travel_r;
        mul_b = cord_res.cos_v;
      end
    endcase
  end

  odo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Position step: round the Q33 product to Q16.16, add and saturate.
  assign rnd     = mul_p + odo_pkg::RND_HALF;
  assign rnd_sh  = rnd >>> odo_pkg::RND_SHIFT;
  assign pos_sel = (state_r == ST_AX) ? x_acc_r : y_acc_r;
  assign pos_sum = {pos_sel[odo_pkg::POS_W-1], pos_sel} + rnd_sh[odo_pkg::POS_W:0];

  always_comb begin
    if (pos_sum[odo_pkg::POS_W] != pos_sum[odo_pkg::POS_W-1]) begin
      pos_sat = pos_sum[odo_pkg::POS_W] ? {1'b1, {(odo_pkg::POS_W-1){1'b0}}}
                                        : {1'b0, {(odo_pkg::POS_W-1){1'b1}}};
    end else begin
      pos_sat = pos_sum[odo_pkg::POS_W-1:0];
    end
  end

  // Heading step with a single wrap; exactly plus or minus pi stays as it is.
  assign th = {ang_r[odo_pkg::ANG_W-1], ang_r} + mul_p[odo_pkg::Z_W-1:0];

  always_comb begin
    if (th > odo_pkg::PI_Q16) begin
      th_wrap = th - odo_pkg::TWO_PI_Q16;
    end else if (th < -odo_pkg::PI_Q16) begin
      th_wrap = th + odo_pkg::TWO_PI_Q16;
    end else begin
      th_wrap = th;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    dl_nxt     = dl_r;
    dr_nxt     = dr_r;
    travel_nxt = travel_r;
    x_acc_nxt  = x_acc_r;
    y_acc_nxt  = y_acc_r;
    ang_nxt    = ang_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dl_nxt    = in_left_delta;
          dr_nxt    = in_right_delta;
          state_nxt = ST_CORD;
        end
      end
      ST_CORD: begin
        if (cord_res.done) begin
          state_nxt = ST_MTRV;
        end
      end
      ST_MTRV: begin
        state_nxt = ST_MX;
      end
      ST_MX: begin
        travel_nxt = mul_p[odo_pkg::TRV_W-1:0];
        state_nxt  = ST_AX;
      end
      ST_AX: begin
        x_acc_nxt = pos_sat;
        state_nxt = ST_AY;
      end
      ST_AY: begin
        y_acc_nxt = pos_sat;
        state_nxt = ST_ATH;
      end
      ST_ATH: begin
        ang_nxt   = th_wrap[odo_pkg::ANG_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    gain_nxt = gain_r;
    if (cfg_valid) begin
      case (cfg_index)
        odo_pkg::REG_STEP_DISTANCE: step_nxt = cfg_data;
        odo_pkg::REG_TURN_GAIN:     gain_nxt = cfg_data[odo_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      gain_r  <= '0;
      x_acc_r <= '0;
      y_acc_r <= '0;
      ang_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      gain_r  <= gain_nxt;
      x_acc_r <= x_acc_nxt;
      y_acc_r <= y_acc_nxt;
      ang_r   <= ang_nxt;
    end
    dl_r     <= dl_nxt;
    dr_r     <= dr_nxt;
    travel_r <= travel_nxt;
  end

  a_ready_xor_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result word is pending");

  a_accept_starts_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CORD))
    else $error("accepted word did not start the CORDIC");

  a_done_in_cord: assert property (@(posedge clk) disable iff (!rst_n)
    cord_res.done |-> (state_r == ST_CORD))
    else $error("CORDIC finished outside its wait state");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_heading <= odo_pkg::PI_Q16) && (out_heading >= -odo_pkg::PI_Q16)))
    else $error("heading left the minus pi to pi range");

endmodule

`default_nettype wire
